FILE: design/hupp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hupp_pkg
// shared widths, register map, reset values and payload types of the
// heading-up point projection pipeline
// ----------------------------------------------------------------------------
package hupp_pkg;

    // field widths
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int POS_W   = 32;
    localparam int TRIG_W  = 16;
    localparam int ZOOM_W  = 15;

    // configuration port
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_USER_EAST  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_USER_NORTH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEAD_SIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEAD_COS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZOOM       = 3'd4;

    localparam logic signed [POS_W-1:0]  RST_USER_EAST  = '0;
    localparam logic signed [POS_W-1:0]  RST_USER_NORTH = '0;
    localparam logic signed [TRIG_W-1:0] RST_HEAD_SIN   = '0;
    localparam logic signed [TRIG_W-1:0] RST_HEAD_COS   = 16'sd32767;
    localparam logic [ZOOM_W-1:0]        RST_ZOOM       = 15'd13107;

    // datapath widths
    localparam int D_W        = POS_W + 1;          // vertex minus user position
    localparam int PROD_W     = D_W + TRIG_W;       // one rotation product
    localparam int ROT_W      = PROD_W + 1;         // rotated coordinate, Q.15
    localparam int SPLIT      = 25;                 // low slice of the scale multiply
    localparam int LO_PROD_W  = SPLIT + ZOOM_W;
    localparam int HI_PROD_W  = ROT_W - SPLIT + ZOOM_W + 1;
    localparam int SCL_W      = 64;                 // scaled coordinate, Q.31
    localparam int FRAC_BITS  = 31;
    localparam int CLAMP_SH   = 48;
    localparam int V_W        = 50;                 // anchored coordinate, Q.31
    localparam int RND_W      = V_W + 1;
    localparam int RQ_W       = RND_W - FRAC_BITS;  // integer part after rounding
    localparam int ANCHOR_W   = 12;

    // cycles from an accepted request to its result strobe
    localparam int LATENCY    = 7;

    typedef struct packed {
        logic signed [IN_W-1:0] east_dm;
        logic signed [IN_W-1:0] north_dm;
    } t_hupp_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
    } t_hupp_res;

    typedef struct packed {
        logic signed [POS_W-1:0]  user_east_dm;
        logic signed [POS_W-1:0]  user_north_dm;
        logic signed [TRIG_W-1:0] heading_sin;
        logic signed [TRIG_W-1:0] heading_cos;
        logic [ZOOM_W-1:0]        zoom_scale;
    } t_hupp_cfg;

endpackage

FILE: design/heading_up_point_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_up_point_projection
// map vertex to heading-up screen pixel: translate, rotate, scale, anchor,
// round and saturate, one vertex per clock
// ----------------------------------------------------------------------------
//  channel   signals                               direction  flow
//  request   start, busy, i_req                    in         start & !busy
//  result    o_done, o_res                         out        strobe, 1 cycle
//  config    psel penable pwrite paddr pwdata      in/out     apb, pready = 1
//            prdata pready
//
//  an accepted request reaches its result through the seven register
//  stages of the datapath
//  one request per cycle, sustained; busy stays low
//  the result cannot be held off, so the pipeline never stalls
//  reset clears the valid bits and loads the register reset values
// ----------------------------------------------------------------------------
module heading_up_point_projection #(
    parameter int ANCHOR_X = 120,
    parameter int ANCHOR_Y = 200
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hupp_pkg::t_hupp_req               i_req,
    output logic                              o_done,
    output hupp_pkg::t_hupp_res               o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hupp_pkg::PADDR_W-1:0]      paddr,
    input  logic [hupp_pkg::PDATA_W-1:0]      pwdata,
    output logic [hupp_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import hupp_pkg::*;

    t_hupp_cfg                 r_cfg;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;
    logic                      rot_vld;
    logic signed [ROT_W-1:0]   rot_xr;
    logic signed [ROT_W-1:0]   rot_yr;
    logic                      scl_vld;
    logic signed [SCL_W-1:0]   scl_p;
    logic signed [SCL_W-1:0]   scl_q;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.user_east_dm  <= RST_USER_EAST;
            r_cfg.user_north_dm <= RST_USER_NORTH;
            r_cfg.heading_sin   <= RST_HEAD_SIN;
            r_cfg.heading_cos   <= RST_HEAD_COS;
            r_cfg.zoom_scale    <= RST_ZOOM;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_USER_EAST:  r_cfg.user_east_dm  <= pwdata;
                REG_USER_NORTH: r_cfg.user_north_dm <= pwdata;
                REG_HEAD_SIN:   r_cfg.heading_sin   <= pwdata[TRIG_W-1:0];
                REG_HEAD_COS:   r_cfg.heading_cos   <= pwdata[TRIG_W-1:0];
                REG_ZOOM:       r_cfg.zoom_scale    <= pwdata[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_USER_EAST:  prdata = r_cfg.user_east_dm;
            REG_USER_NORTH: prdata = r_cfg.user_north_dm;
            REG_HEAD_SIN:   prdata = {{(PDATA_W-TRIG_W){r_cfg.heading_sin[TRIG_W-1]}},
                                      r_cfg.heading_sin};
            REG_HEAD_COS:   prdata = {{(PDATA_W-TRIG_W){r_cfg.heading_cos[TRIG_W-1]}},
                                      r_cfg.heading_cos};
            REG_ZOOM:       prdata = {{(PDATA_W-ZOOM_W){1'b0}}, r_cfg.zoom_scale};
            default:        prdata = '0;
        endcase
    end

    // translate and rotate
    hupp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .o_vld   (rot_vld),
        .o_xr    (rot_xr),
        .o_yr    (rot_yr)
    );

    // zoom
    hupp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rot_vld),
        .i_xr    (rot_xr),
        .i_yr    (rot_yr),
        .i_zoom  (r_cfg.zoom_scale),
        .o_vld   (scl_vld),
        .o_p     (scl_p),
        .o_q     (scl_q)
    );

    // anchor, round, saturate
    hupp_place #(
        .ANCHOR_X (ANCHOR_X),
        .ANCHOR_Y (ANCHOR_Y)
    ) u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (scl_vld),
        .i_p     (scl_p),
        .i_q     (scl_q),
        .o_vld   (o_done),
        .o_res   (o_res)
    );

endmodule

FILE: design/hupp_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hupp_rotate
// three stages: subtract user position, four rotation products, sum and
// difference giving the heading-up coordinates in Q.15
// ----------------------------------------------------------------------------
module hupp_rotate (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_vld,
    input  hupp_pkg::t_hupp_req                        i_req,
    input  hupp_pkg::t_hupp_cfg                        i_cfg,
    output logic                                       o_vld,
    output logic signed [hupp_pkg::ROT_W-1:0]          o_xr,
    output logic signed [hupp_pkg::ROT_W-1:0]          o_yr
);
    import hupp_pkg::*;

    logic [2:0]                r_vld;
    logic signed [D_W-1:0]     r_de;
    logic signed [D_W-1:0]     r_dn;
    logic signed [D_W-1:0]     n_de;
    logic signed [D_W-1:0]     n_dn;
    logic signed [PROD_W-1:0]  r_de_cos;
    logic signed [PROD_W-1:0]  r_dn_sin;
    logic signed [PROD_W-1:0]  r_de_sin;
    logic signed [PROD_W-1:0]  r_dn_cos;
    logic signed [ROT_W-1:0]   r_xr;
    logic signed [ROT_W-1:0]   r_yr;

    // offset from the user, sign extended to full width
    always_comb begin
        n_de = $signed({{(D_W-IN_W){i_req.east_dm[IN_W-1]}}, i_req.east_dm})
             - $signed({i_cfg.user_east_dm[POS_W-1], i_cfg.user_east_dm});
        n_dn = $signed({{(D_W-IN_W){i_req.north_dm[IN_W-1]}}, i_req.north_dm})
             - $signed({i_cfg.user_north_dm[POS_W-1], i_cfg.user_north_dm});
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_de     <= n_de;
        r_dn     <= n_dn;
        r_de_cos <= r_de * $signed(i_cfg.heading_cos);
        r_dn_sin <= r_dn * $signed(i_cfg.heading_sin);
        r_de_sin <= r_de * $signed(i_cfg.heading_sin);
        r_dn_cos <= r_dn * $signed(i_cfg.heading_cos);
        r_xr     <= ROT_W'(r_de_cos) - ROT_W'(r_dn_sin);
        r_yr     <= ROT_W'(r_de_sin) + ROT_W'(r_dn_cos);
    end

    assign o_vld = r_vld[2];
    assign o_xr  = r_xr;
    assign o_yr  = r_yr;

endmodule

FILE: design/hupp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hupp_scale
// two stages: zoom multiply split into a low and a high partial product,
// then recombination into the Q.31 screen offset
// ----------------------------------------------------------------------------
module hupp_scale (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_vld,
    input  logic signed [hupp_pkg::ROT_W-1:0]          i_xr,
    input  logic signed [hupp_pkg::ROT_W-1:0]          i_yr,
    input  logic [hupp_pkg::ZOOM_W-1:0]                i_zoom,
    output logic                                       o_vld,
    output logic signed [hupp_pkg::SCL_W-1:0]          o_p,
    output logic signed [hupp_pkg::SCL_W-1:0]          o_q
);
    import hupp_pkg::*;

    logic [1:0]                  r_vld;
    logic [LO_PROD_W-1:0]        r_lo_x;
    logic [LO_PROD_W-1:0]        r_lo_y;
    logic signed [HI_PROD_W-1:0] r_hi_x;
    logic signed [HI_PROD_W-1:0] r_hi_y;
    logic signed [SCL_W-1:0]     r_p;
    logic signed [SCL_W-1:0]     r_q;
    logic signed [ZOOM_W:0]      zoom_s;

    assign zoom_s = $signed({1'b0, i_zoom});

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    // partial products, then shift and add
    always_ff @(posedge i_clk) begin
        r_lo_x <= LO_PROD_W'(i_xr[SPLIT-1:0]) * LO_PROD_W'(i_zoom);
        r_lo_y <= LO_PROD_W'(i_yr[SPLIT-1:0]) * LO_PROD_W'(i_zoom);
        r_hi_x <= $signed(i_xr[ROT_W-1:SPLIT]) * zoom_s;
        r_hi_y <= $signed(i_yr[ROT_W-1:SPLIT]) * zoom_s;
        r_p    <= (SCL_W'(r_hi_x) <<< SPLIT) + $signed(SCL_W'(r_lo_x));
        r_q    <= (SCL_W'(r_hi_y) <<< SPLIT) + $signed(SCL_W'(r_lo_y));
    end

    assign o_vld = r_vld[1];
    assign o_p   = r_p;
    assign o_q   = r_q;

endmodule

FILE: design/hupp_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hupp_place
// two stages: clamp far points and add the screen anchor, then round half
// away from zero and saturate to 16 bits; y grows downward
// ----------------------------------------------------------------------------
module hupp_place #(
    parameter int ANCHOR_X = 120,
    parameter int ANCHOR_Y = 200
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_vld,
    input  logic signed [hupp_pkg::SCL_W-1:0]          i_p,
    input  logic signed [hupp_pkg::SCL_W-1:0]          i_q,
    output logic                                       o_vld,
    output hupp_pkg::t_hupp_res                        o_res
);
    import hupp_pkg::*;

    localparam logic signed [V_W-1:0]   AX_Q     = V_W'(ANCHOR_X) <<< FRAC_BITS;
    localparam logic signed [V_W-1:0]   AY_Q     = V_W'(ANCHOR_Y) <<< FRAC_BITS;
    localparam logic signed [SCL_W-1:0] LIM_HI   = SCL_W'(1) <<< CLAMP_SH;
    localparam logic signed [SCL_W-1:0] LIM_LO   = -LIM_HI;
    localparam logic signed [RND_W-1:0] HALF     = RND_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] HALF_M1  = HALF - RND_W'(1);
    localparam logic signed [RQ_W-1:0]  SAT_HI   = RQ_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RQ_W-1:0]  SAT_LO   = -SAT_HI - RQ_W'(1);

    logic [1:0]              r_vld;
    logic signed [V_W-1:0]   r_vx;
    logic signed [V_W-1:0]   r_vy;
    logic signed [V_W-1:0]   n_vx;
    logic signed [V_W-1:0]   n_vy;
    t_hupp_res               r_res;
    t_hupp_res               n_res;

    // clamp to the far-point limit, narrowed to the anchored width
    function automatic logic signed [V_W-1:0] clamp_off(input logic signed [SCL_W-1:0] v);
        logic signed [V_W-1:0] c;
        if (v > LIM_HI) begin
            c = V_W'(LIM_HI);
        end else if (v < LIM_LO) begin
            c = V_W'(LIM_LO);
        end else begin
            c = V_W'(v);
        end
        return c;
    endfunction

    // round half away from zero, then saturate
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [V_W-1:0] v);
        logic signed [RND_W-1:0] s;
        logic signed [RQ_W-1:0]  r;
        logic signed [OUT_W-1:0] o;
        s = RND_W'(v) + (v[V_W-1] ? HALF_M1 : HALF);
        r = $signed(s[RND_W-1:FRAC_BITS]);
        if (r > SAT_HI) begin
            o = OUT_W'(SAT_HI);
        end else if (r < SAT_LO) begin
            o = OUT_W'(SAT_LO);
        end else begin
            o = OUT_W'(r);
        end
        return o;
    endfunction

    // anchor add, and round and saturate of the registered anchored values; y runs opposite to north
    always_comb begin
        n_vx = AX_Q + clamp_off(i_p);
        n_vy = AY_Q - clamp_off(i_q);
        n_res.screen_x = round_sat(r_vx);
        n_res.screen_y = round_sat(r_vy);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_vx  <= n_vx;
        r_vy  <= n_vy;
        r_res <= n_res;
    end

    assign o_vld = r_vld[1];
    assign o_res = r_res;

endmodule

FILE: design/hupp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hupp_checker
// port-level checks: fixed latency in both directions, no back-pressure
// ----------------------------------------------------------------------------
module hupp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  logic o_done,
    input  logic pready
);
    import hupp_pkg::*;

    // every accepted request yields its result after the pipeline depth
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("request without result at pipeline depth");

    // no result strobe without a request at pipeline depth
    a_done_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching request");

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // config port is zero wait state
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind heading_up_point_projection hupp_checker u_hupp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .pready  (pready)
);
